// ===== sv/gmfc_pkg.sv =====
package gmfc_pkg;

    // Request kinds
    localparam logic [1:0] REQ_STREAM  = 2'd0;
    localparam logic [1:0] REQ_PAYLOAD = 2'd1;
    localparam logic [1:0] REQ_END     = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_CONSUMED   = 3'd0;
    localparam logic [2:0] ST_HDR_OK     = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC  = 3'd2;
    localparam logic [2:0] ST_TRL_OK     = 3'd3;
    localparam logic [2:0] ST_TRL_MISMATCH = 3'd4;
    localparam logic [2:0] ST_IGNORED    = 3'd5;

    localparam logic [31:0] CRC_ONES = 32'hffff_ffff;
    localparam logic [31:0] CRC_POLY = 32'hedb8_8320;

    // One result beat
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] crc_now;
        logic [7:0]  header_flags;
    } result_t;

endpackage

// ===== sv/gzip_member_frame_checker.sv =====
// gzip member frame checker.
// Input channel (in_valid/in_ready): req_type selects a compressed-stream byte,
// a decompressed payload byte or the end-of-payload marker; data_byte carries
// the byte. Output channel (out_valid/out_ready): one result beat per input
// beat, in order, with status, the finalised CRC-32 of the member payload so
// far and the member's flag byte.
// A beat accepted into the input register is processed by the parser logic and
// lands in the output register when it advances, which waits while the output
// register holds a result that the receiver has not taken.
// Throughput: one beat per cycle while the receiver takes results; the bytewise
// CRC-32 XOR network and the framing logic sit between the input and output registers.
// When the receiver stalls, the output register holds its result and the
// input register holds one further beat; in_ready falls only while both are
// full and out_ready is low.
// Reset clears both valid bits and puts the parser between members with the
// CRC at all ones; any framing error sticks until the next reset.
module gzip_member_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] crc_now,
    output logic [7:0]  header_flags
);

    logic              in_valid_reg;
    logic [1:0]        type_reg;
    logic [7:0]        byte_reg;
    logic              out_valid_reg;
    gmfc_pkg::result_t res_reg;
    gmfc_pkg::result_t res;
    logic              advance;

    // Beat moves from input register to output register
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    gmfc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .req_type  (type_reg),
        .data_byte (byte_reg),
        .res       (res)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            type_reg <= req_type;
            byte_reg <= data_byte;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign status       = res_reg.status;
    assign crc_now      = res_reg.crc_now;
    assign header_flags = res_reg.header_flags;

endmodule

// ===== sv/gmfc_crc32.sv =====
// Reflected CRC-32 update by one byte, as a flat XOR network
module gmfc_crc32 (
    input  logic [31:0] crc_in,
    input  logic [7:0]  data,
    output logic [31:0] crc_out
);

    always_comb
    begin
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ gmfc_pkg::CRC_POLY) : (c >> 1);
        end
        crc_out = c;
    end

endmodule

// ===== sv/gmfc_parser.sv =====
// Member framing state and per-beat next-state logic
module gmfc_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [1:0]          req_type,
    input  logic [7:0]          data_byte,
    output gmfc_pkg::result_t   res
);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_HEADER  = 4'd1;
    localparam logic [3:0] PH_XLEN_LO = 4'd2;
    localparam logic [3:0] PH_XLEN_HI = 4'd3;
    localparam logic [3:0] PH_EXTRA   = 4'd4;
    localparam logic [3:0] PH_NAME    = 4'd5;
    localparam logic [3:0] PH_COMMENT = 4'd6;
    localparam logic [3:0] PH_HCRC    = 4'd7;
    localparam logic [3:0] PH_PAYLOAD = 4'd8;
    localparam logic [3:0] PH_TRAILER = 4'd9;
    localparam logic [3:0] PH_ERROR   = 4'd10;

    localparam int FLAG_HCRC    = 1;
    localparam int FLAG_EXTRA   = 2;
    localparam int FLAG_NAME    = 3;
    localparam int FLAG_COMMENT = 4;

    localparam logic [15:0] GZ_MAGIC     = 16'h8b1f;
    localparam logic [15:0] HDR_LEN      = 16'd10;
    localparam logic [15:0] HCRC_LEN     = 16'd2;
    localparam logic [15:0] TRL_LEN      = 16'd8;

    logic [3:0]  phase_reg, phase_next;
    logic [7:0]  flags_reg, flags_next;
    logic [15:0] count_reg, count_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] len_reg, len_next;
    logic        mism_reg, mism_next;
    logic [7:0]  magic_lo_reg, magic_lo_next;
    logic [2:0]  status;

    logic [31:0] crc_upd;
    logic [31:0] trl_src;
    logic [31:0] trl_shift;
    logic [15:0] count_inc;

    // First header part present at or after 'from'
    function automatic logic [3:0] next_part(input logic [3:0] from, input logic [7:0] flags);
        logic [3:0] ph;
        ph = PH_PAYLOAD;
        if (from <= PH_HCRC && flags[FLAG_HCRC])
            ph = PH_HCRC;
        if (from <= PH_COMMENT && flags[FLAG_COMMENT])
            ph = PH_COMMENT;
        if (from <= PH_NAME && flags[FLAG_NAME])
            ph = PH_NAME;
        if (from <= PH_XLEN_LO && flags[FLAG_EXTRA])
            ph = PH_XLEN_LO;
        return ph;
    endfunction

    gmfc_crc32 u_crc (
        .crc_in  (crc_reg),
        .data    (data_byte),
        .crc_out (crc_upd)
    );

    assign count_inc = count_reg + 16'd1;
    // Trailer byte expected: CRC bytes first, then length, little endian
    assign trl_src   = count_reg[2] ? len_reg : (crc_reg ^ gmfc_pkg::CRC_ONES);
    assign trl_shift = trl_src >> {count_reg[1:0], 3'b000};

    // Next state and status for one beat
    always_comb
    begin
        phase_next    = phase_reg;
        flags_next    = flags_reg;
        count_next    = count_reg;
        crc_next      = crc_reg;
        len_next      = len_reg;
        mism_next     = mism_reg;
        magic_lo_next = magic_lo_reg;
        status        = gmfc_pkg::ST_CONSUMED;

        if (phase_reg >= PH_ERROR)
        begin
            status = gmfc_pkg::ST_IGNORED;
        end
        else if (req_type == gmfc_pkg::REQ_STREAM)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (data_byte != 8'd0)
                    begin
                        crc_next      = gmfc_pkg::CRC_ONES;
                        len_next      = 32'd0;
                        mism_next     = 1'b0;
                        magic_lo_next = data_byte;
                        count_next    = 16'd1;
                        phase_next    = PH_HEADER;
                    end
                end
                PH_HEADER:
                begin
                    if (count_reg == 16'd1 && {data_byte, magic_lo_reg} != GZ_MAGIC)
                    begin
                        phase_next = PH_ERROR;
                        status     = gmfc_pkg::ST_BAD_MAGIC;
                    end
                    else
                    begin
                        if (count_reg == 16'd3)
                            flags_next = data_byte;
                        count_next = count_inc;
                        if (count_inc >= HDR_LEN)
                        begin
                            count_next = 16'd0;
                            phase_next = next_part(PH_XLEN_LO, flags_reg);
                        end
                    end
                end
                PH_XLEN_LO:
                begin
                    count_next = {8'd0, data_byte};
                    phase_next = PH_XLEN_HI;
                end
                PH_XLEN_HI:
                begin
                    count_next = {data_byte, count_reg[7:0]};
                    if ({data_byte, count_reg[7:0]} == 16'd0)
                        phase_next = next_part(PH_NAME, flags_reg);
                    else
                        phase_next = PH_EXTRA;
                end
                PH_EXTRA:
                begin
                    count_next = count_reg - 16'd1;
                    if (count_reg == 16'd1)
                    begin
                        count_next = 16'd0;
                        phase_next = next_part(PH_NAME, flags_reg);
                    end
                end
                PH_NAME:
                begin
                    if (data_byte == 8'd0)
                    begin
                        count_next = 16'd0;
                        phase_next = next_part(PH_COMMENT, flags_reg);
                    end
                end
                PH_COMMENT:
                begin
                    if (data_byte == 8'd0)
                    begin
                        count_next = 16'd0;
                        phase_next = next_part(PH_HCRC, flags_reg);
                    end
                end
                PH_HCRC:
                begin
                    count_next = count_inc;
                    if (count_inc >= HCRC_LEN)
                    begin
                        count_next = 16'd0;
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    status = gmfc_pkg::ST_CONSUMED;
                end
                PH_TRAILER:
                begin
                    if (trl_shift[7:0] != data_byte)
                        mism_next = 1'b1;
                    count_next = count_inc;
                    if (count_inc >= TRL_LEN)
                    begin
                        count_next = 16'd0;
                        if (mism_next)
                        begin
                            phase_next = PH_ERROR;
                            status     = gmfc_pkg::ST_TRL_MISMATCH;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            status     = gmfc_pkg::ST_TRL_OK;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_ERROR;
                    status     = gmfc_pkg::ST_IGNORED;
                end
            endcase

            // Header completion is flagged on the beat that reaches the payload
            if (phase_reg != PH_PAYLOAD && phase_reg != PH_IDLE &&
                phase_next == PH_PAYLOAD)
                status = gmfc_pkg::ST_HDR_OK;
        end
        else if (req_type == gmfc_pkg::REQ_PAYLOAD && phase_reg == PH_PAYLOAD)
        begin
            crc_next = crc_upd;
            len_next = len_reg + 32'd1;
        end
        else if (req_type == gmfc_pkg::REQ_END && phase_reg == PH_PAYLOAD)
        begin
            phase_next = PH_TRAILER;
            count_next = 16'd0;
            mism_next  = 1'b0;
        end
        else
        begin
            status = gmfc_pkg::ST_IGNORED;
        end
    end

    assign res.status       = status;
    assign res.crc_now      = crc_next ^ gmfc_pkg::CRC_ONES;
    assign res.header_flags = flags_next;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            flags_reg    <= 8'd0;
            count_reg    <= 16'd0;
            crc_reg      <= gmfc_pkg::CRC_ONES;
            len_reg      <= 32'd0;
            mism_reg     <= 1'b0;
            magic_lo_reg <= 8'd0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            flags_reg    <= flags_next;
            count_reg    <= count_next;
            crc_reg      <= crc_next;
            len_reg      <= len_next;
            mism_reg     <= mism_next;
            magic_lo_reg <= magic_lo_next;
        end
    end

    // Errors are sticky
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ERROR |=> phase_reg == PH_ERROR)
        else $error("error phase left before reset");

    a_error_ignores: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_ERROR |-> res.status == gmfc_pkg::ST_IGNORED)
        else $error("beat in error phase not ignored");

    a_bad_magic_err: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.status == gmfc_pkg::ST_BAD_MAGIC |=> phase_reg == PH_ERROR)
        else $error("bad magic did not enter error phase");

    a_hdr_ok_payload: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.status == gmfc_pkg::ST_HDR_OK |=> phase_reg == PH_PAYLOAD)
        else $error("header ok without payload phase");

    a_trl_ok_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.status == gmfc_pkg::ST_TRL_OK |=> phase_reg == PH_IDLE && count_reg == 16'd0)
        else $error("trailer ok did not return to idle");

endmodule
